// ===== sv/sqrot90_pkg.sv =====
// Shared constants for the square image rotation unit.
`timescale 1ns / 1ps

package sqrot90_pkg;

   // Fixed field widths of the ports.
   localparam int CSR_W  = 6;
   localparam int DATA_W = 16;

   // Reset value of the side length register.
   localparam logic [CSR_W-1:0] SIDE_RESET = 6'd32;

   // Defaults for the top-level parameters.
   localparam int MAX_SIDE_DEF   = 32;
   localparam int PIXEL_BITS_DEF = 16;

endpackage

// ===== sv/square_image_rotate_90_unit.sv =====
// Square image rotation by 90 degrees clockwise with ping-pong pixel banks.
`timescale 1ns / 1ps

// Pixels of a square image arrive in row-major order on the req channel and are
// written into one of two banks of a single-port-write, single-port-read memory.
// When a bank holds side*side pixels the banks swap, and every following item
// (with or without a pixel) emits one pixel of the rotated frame in row-major
// order, with rsp_tlast on the final pixel of a frame. Filling and draining run
// in lockstep, one item per clock while rsp_tready is high and no register
// write is pending or being processed; the memory read is registered and that
// register doubles as the output stage. A write to csr_wdata sets the side
// length (0 acts as 1, values above MAX_SIDE act as MAX_SIDE); afterwards a
// restoring divider re-derives the fill row and column, during which no item is
// taken. The pixel memory is not cleared at reset.
module square_image_rotate_90_unit #(
   parameter int MAX_SIDE   = sqrot90_pkg::MAX_SIDE_DEF,
   parameter int PIXEL_BITS = sqrot90_pkg::PIXEL_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input item.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sqrot90_pkg::DATA_W-1:0]  req_tdata,   // [15:0] pixel_value
   input  logic                            req_tuser,   // [0] pixel_present
   // Result item.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sqrot90_pkg::DATA_W-1:0]  rsp_tdata,   // [15:0] rotated_value
   output logic                            rsp_tlast,   // frame_last
   // Side length register write.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sqrot90_pkg::CSR_W-1:0]   csr_wdata
);
   import sqrot90_pkg::*;

   localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int TOT_W  = 2 * SIDE_W;
   localparam int CNT_W  = $clog2(MAX_SIDE * MAX_SIDE + 1);
   localparam int DCNT_W = $clog2(CNT_W + 1);
   localparam int ADDR_W = 2 * IDX_W + 1;
   localparam int DEPTH  = 2 ** ADDR_W;

   // Registers.
   logic [CSR_W-1:0]      side_ff;
   logic [CNT_W-1:0]      fill_count_ff, fill_count_in;
   logic [IDX_W-1:0]      fill_row_ff, fill_row_in;
   logic [IDX_W-1:0]      fill_col_ff, fill_col_in;
   logic                  fill_bank_ff, fill_bank_in;
   logic [IDX_W-1:0]      drain_row_ff, drain_row_in;
   logic [IDX_W-1:0]      drain_col_ff, drain_col_in;
   logic                  drain_pending_ff, drain_pending_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_last_ff;
   logic [PIXEL_BITS-1:0] rd_data_ff;
   logic [DCNT_W-1:0]     div_cnt_ff, div_cnt_in;
   logic [CNT_W-1:0]      div_quo_ff, div_quo_in;
   logic [SIDE_W-1:0]     div_rem_ff, div_rem_in;

   logic [PIXEL_BITS-1:0] bank_mem [DEPTH];

   // Working signals.
   logic              req_acc;
   logic              csr_acc;
   logic              div_busy;
   logic [SIDE_W-1:0] side_n;
   logic [TOT_W-1:0]  total;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [IDX_W-1:0]  src_row;
   logic              last_in;
   logic              fill_done;
   logic [CNT_W-1:0]  base_count;
   logic [IDX_W-1:0]  base_row;
   logic [IDX_W-1:0]  base_col;
   logic [CNT_W-1:0]  count_p1;
   logic [SIDE_W:0]   div_trial;
   logic              div_bit;

   assign div_busy   = (div_cnt_ff != '0);
   assign csr_ready  = !div_busy;
   assign csr_acc    = csr_valid && csr_ready;
   // A pending register write takes priority so the divider sees a settled count.
   assign req_tready = !div_busy && !csr_valid && (!rsp_valid_ff || rsp_tready);
   assign req_acc    = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rd_data_ff);
   assign rsp_tlast  = rsp_last_ff;

   // Effective side length.
   always_comb begin
      if (side_ff == '0) begin
         side_n = SIDE_W'(1);
      end else if (int'(side_ff) > MAX_SIDE) begin
         side_n = SIDE_W'(MAX_SIDE);
      end else begin
         side_n = SIDE_W'(side_ff);
      end
   end

   assign total = TOT_W'(side_n) * TOT_W'(side_n);

   // Drain read: output (r,c) comes from input (n-1-c, r) of the full bank.
   always_comb begin
      if (SIDE_W'(drain_col_ff) < side_n) begin
         src_row = IDX_W'(side_n - SIDE_W'(1) - SIDE_W'(drain_col_ff));
      end else begin
         src_row = '0;
      end
   end

   assign rd_en   = req_acc && drain_pending_ff;
   assign rd_addr = {~fill_bank_ff, src_row, drain_row_ff};

   // Fill position; a count left beyond the frame by a side change restarts it.
   always_comb begin
      if (TOT_W'(fill_count_ff) >= total) begin
         base_count = '0;
         base_row   = '0;
         base_col   = '0;
      end else begin
         base_count = fill_count_ff;
         base_row   = fill_row_ff;
         base_col   = fill_col_ff;
      end
   end

   assign count_p1  = base_count + CNT_W'(1);
   assign wr_en     = req_acc && req_tuser;
   assign wr_addr   = {fill_bank_ff, base_row, base_col};
   assign fill_done = wr_en && (TOT_W'(count_p1) >= total);

   // Divider step that maps the fill count onto row and column after a side change.
   always_comb begin
      div_trial = {div_rem_ff, div_quo_ff[CNT_W-1]};
      div_bit   = (div_trial >= {1'b0, side_n});
      div_quo_in = CNT_W'({div_quo_ff, div_bit});
      if (div_bit) begin
         div_rem_in = SIDE_W'(div_trial - {1'b0, side_n});
      end else begin
         div_rem_in = SIDE_W'(div_trial);
      end
      div_cnt_in = div_cnt_ff;
      if (csr_acc) begin
         div_cnt_in = DCNT_W'(CNT_W);
         div_quo_in = fill_count_ff;
         div_rem_in = '0;
      end else if (div_busy) begin
         div_cnt_in = div_cnt_ff - DCNT_W'(1);
      end
   end

   // Next state of the counters; the fill update follows the drain update.
   always_comb begin
      fill_count_in    = fill_count_ff;
      fill_row_in      = fill_row_ff;
      fill_col_in      = fill_col_ff;
      fill_bank_in     = fill_bank_ff;
      drain_row_in     = drain_row_ff;
      drain_col_in     = drain_col_ff;
      drain_pending_in = drain_pending_ff;
      last_in          = 1'b0;

      if (rd_en) begin
         if (SIDE_W'(drain_col_ff) + SIDE_W'(1) >= side_n) begin
            drain_col_in = '0;
            if (SIDE_W'(drain_row_ff) + SIDE_W'(1) >= side_n) begin
               drain_row_in     = '0;
               drain_pending_in = 1'b0;
               last_in          = 1'b1;
            end else begin
               drain_row_in = drain_row_ff + IDX_W'(1);
            end
         end else begin
            drain_col_in = drain_col_ff + IDX_W'(1);
         end
      end

      if (wr_en) begin
         if (fill_done) begin
            fill_count_in    = '0;
            fill_row_in      = '0;
            fill_col_in      = '0;
            fill_bank_in     = ~fill_bank_ff;
            drain_row_in     = '0;
            drain_col_in     = '0;
            drain_pending_in = 1'b1;
         end else begin
            fill_count_in = count_p1;
            if (SIDE_W'(base_col) + SIDE_W'(1) >= side_n) begin
               fill_col_in = '0;
               fill_row_in = base_row + IDX_W'(1);
            end else begin
               fill_col_in = base_col + IDX_W'(1);
               fill_row_in = base_row;
            end
         end
      end else if (div_cnt_ff == DCNT_W'(1)) begin
         // Final divider step: quotient is the row, remainder the column.
         fill_row_in = IDX_W'(div_quo_in);
         fill_col_in = IDX_W'(div_rem_in);
      end
   end

   always_comb begin
      if (req_acc) begin
         rsp_valid_in = drain_pending_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff          <= SIDE_RESET;
         fill_count_ff    <= '0;
         fill_row_ff      <= '0;
         fill_col_ff      <= '0;
         fill_bank_ff     <= 1'b0;
         drain_row_ff     <= '0;
         drain_col_ff     <= '0;
         drain_pending_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         div_cnt_ff       <= '0;
      end else begin
         if (csr_acc) begin
            side_ff <= csr_wdata;
         end
         fill_count_ff    <= fill_count_in;
         fill_row_ff      <= fill_row_in;
         fill_col_ff      <= fill_col_in;
         fill_bank_ff     <= fill_bank_in;
         drain_row_ff     <= drain_row_in;
         drain_col_ff     <= drain_col_in;
         drain_pending_ff <= drain_pending_in;
         rsp_valid_ff     <= rsp_valid_in;
         div_cnt_ff       <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      div_quo_ff <= div_quo_in;
      div_rem_ff <= div_rem_in;
      if (rd_en) begin
         rsp_last_ff <= last_in;
      end
   end

   // Pixel memory: the two banks share one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bank_mem[wr_addr] <= PIXEL_BITS'(req_tdata);
      end
      if (rd_en) begin
         rd_data_ff <= bank_mem[rd_addr];
      end
   end

   // An item taken while a bank is draining always produces a result.
   assert property (@(posedge clock) disable iff (reset)
      rd_en |=> rsp_tvalid)
      else $error("drained item produced no result");

   // No item is taken while the fill position is being recomputed.
   assert property (@(posedge clock) disable iff (reset)
      div_busy |-> !req_tready)
      else $error("item accepted during fill position recompute");

   // The last pixel of a frame ends the drain unless another bank just filled.
   assert property (@(posedge clock) disable iff (reset)
      (rd_en && last_in && !fill_done) |=> !drain_pending_ff)
      else $error("drain still pending after frame end");

   // The divider only starts after a register write.
   assert property (@(posedge clock) disable iff (reset)
      $rose(div_busy) |-> $past(csr_valid && csr_ready))
      else $error("divider started without a register write");

endmodule
